// ===== design/timestamp_kway_merge_macros.svh =====
`ifndef TIMESTAMP_KWAY_MERGE_MACROS_SVH
`define TIMESTAMP_KWAY_MERGE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TKM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define TKM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/tkm_pkg.sv =====
package tkm_pkg;

  localparam int unsigned CFG_W     = 5;
  localparam int unsigned LANE_W    = 4;
  localparam int unsigned SEC_W     = 32;
  localparam int unsigned USEC_W    = 20;
  localparam int unsigned KEY_W     = SEC_W + USEC_W;
  localparam int unsigned RST_LANES = 16;
  localparam int unsigned Q_DEPTH   = 2;
  localparam int unsigned Q_AW      = 1;

  typedef enum logic {
    KIND_HEAD,
    KIND_END
  } tkm_kind_t;

  typedef struct packed {
    tkm_kind_t           kind;
    logic [LANE_W-1:0]   lane;
    logic [SEC_W-1:0]    sec;
    logic [USEC_W-1:0]   usec;
  } tkm_item_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_CHECK,
    BK_SCAN,
    BK_DRAIN,
    BK_EMIT,
    BK_FIN
  } tkm_state_t;

endpackage

// ===== design/tkm_if.sv =====
interface tkm_in_if;
  logic                        valid;
  logic                        ready;
  logic [tkm_pkg::LANE_W-1:0]  lane;
  logic                        lane_end;
  logic [tkm_pkg::SEC_W-1:0]   head_sec;
  logic [tkm_pkg::USEC_W-1:0]  head_usec;

  modport source (output valid, lane, lane_end, head_sec, head_usec, input ready);
  modport sink (input valid, lane, lane_end, head_sec, head_usec, output ready);
endinterface

interface tkm_out_if;
  logic                        valid;
  logic                        ready;
  logic [tkm_pkg::LANE_W-1:0]  chosen_lane;
  logic [tkm_pkg::SEC_W-1:0]   chosen_sec;
  logic [tkm_pkg::USEC_W-1:0]  chosen_usec;
  logic                        finished;

  modport source (output valid, chosen_lane, chosen_sec, chosen_usec, finished,
                  input ready);
  modport sink (input valid, chosen_lane, chosen_sec, chosen_usec, finished,
                output ready);
endinterface

interface tkm_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [tkm_pkg::CFG_W-1:0]   data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== design/tkm_front.sv =====
module tkm_front #(
  parameter int unsigned LANES = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  tkm_in_if.sink                       in_ch,
  tkm_cfg_if.sink                      cfg_ch,
  output logic                         push_valid,
  input  logic                         push_ready,
  output tkm_pkg::tkm_item_t           push_item,
  output logic [$clog2(LANES+1)-1:0]   lane_count
);

  localparam int unsigned CNTW    = $clog2(LANES + 1);
  localparam int unsigned CMPW    = (CNTW > tkm_pkg::CFG_W) ? CNTW : tkm_pkg::CFG_W;
  localparam int unsigned RST_CNT = (LANES < tkm_pkg::RST_LANES) ? LANES : tkm_pkg::RST_LANES;

  logic [CNTW-1:0] cnt_r;
  logic [CNTW-1:0] cnt_nxt;
  logic [CMPW-1:0] cfg_wide;
  logic            lane_ok;

  assign cfg_ch.ready = 1'b1;
  assign cfg_wide     = CMPW'(cfg_ch.data);

  // The register value is clamped once, when written.
  always_comb begin
    cnt_nxt = cnt_r;
    if (cfg_ch.valid) begin
      priority if (cfg_wide == '0) begin
        cnt_nxt = CNTW'(1);
      end else if (cfg_wide > CMPW'(LANES)) begin
        cnt_nxt = CNTW'(LANES);
      end else begin
        cnt_nxt = CNTW'(cfg_wide);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= CNTW'(RST_CNT);
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  assign lane_count = cnt_r;

  // Requests for lanes outside the merge are accepted and dropped here.
  assign lane_ok     = CMPW'(in_ch.lane) < CMPW'(cnt_r);
  assign in_ch.ready = push_ready;
  assign push_valid  = in_ch.valid && lane_ok;

  always_comb begin
    push_item.kind = in_ch.lane_end ? tkm_pkg::KIND_END : tkm_pkg::KIND_HEAD;
    push_item.lane = in_ch.lane;
    push_item.sec  = in_ch.head_sec;
    push_item.usec = in_ch.head_usec;
  end

endmodule

// ===== design/tkm_queue.sv =====
module tkm_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  output logic                push_ready,
  input  tkm_pkg::tkm_item_t  push_item,
  output logic                pop_valid,
  input  logic                pop_ready,
  output tkm_pkg::tkm_item_t  pop_item
);

  tkm_pkg::tkm_item_t          q_mem_r [tkm_pkg::Q_DEPTH];
  logic [tkm_pkg::Q_AW-1:0]    wr_ptr_r;
  logic [tkm_pkg::Q_AW-1:0]    rd_ptr_r;
  logic [tkm_pkg::Q_AW:0]      cnt_r;
  logic                        do_push;
  logic                        do_pop;

  assign push_ready = cnt_r != (tkm_pkg::Q_AW + 1)'(tkm_pkg::Q_DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_item   = q_mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ===== design/tkm_back.sv =====
module tkm_back #(
  parameter int unsigned LANES = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [$clog2(LANES+1)-1:0]   lane_count,
  input  logic                         pop_valid,
  output logic                         pop_ready,
  input  tkm_pkg::tkm_item_t           pop_item,
  tkm_out_if.source                    out_ch
);

  localparam int unsigned LW   = $clog2(LANES);
  localparam int unsigned CNTW = $clog2(LANES + 1);
  localparam int unsigned KW   = tkm_pkg::KEY_W;

  tkm_pkg::tkm_state_t state_r, state_nxt;

  logic [LANES-1:0] live_r, live_nxt;
  logic [LANES-1:0] present_r, present_nxt;
  logic [LANES-1:0] lane_mask;
  logic [LANES-1:0] act_live;
  logic             done_r, done_nxt;

  logic [LW-1:0]    idx_r, idx_nxt;
  logic             cmp_vld_r, cmp_vld_nxt;
  logic [LW-1:0]    cmp_idx_r, cmp_idx_nxt;
  logic             best_vld_r, best_vld_nxt;
  logic [LW-1:0]    best_idx_r, best_idx_nxt;
  logic [KW-1:0]    best_key_r, best_key_nxt;
  logic             take_best;

  logic [KW-1:0]    key_mem [LANES];
  logic [KW-1:0]    rdata_r;
  logic             mem_we;
  logic             mem_re;
  logic [LW-1:0]    item_idx;

  logic                        out_valid_r, out_valid_nxt;
  logic [tkm_pkg::LANE_W-1:0]  out_lane_r, out_lane_nxt;
  logic [tkm_pkg::SEC_W-1:0]   out_sec_r, out_sec_nxt;
  logic [tkm_pkg::USEC_W-1:0]  out_usec_r, out_usec_nxt;
  logic                        out_fin_r, out_fin_nxt;
  logic                        out_free;

  assign item_idx = LW'(pop_item.lane);
  assign out_free = !out_valid_r || out_ch.ready;
  assign act_live = live_r & lane_mask;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      lane_mask[i] = CNTW'(i) < lane_count;
    end
  end

  // Head store: written when a head arrives, read one lane per cycle during a scan.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      key_mem[item_idx] <= {pop_item.sec, pop_item.usec};
    end
    if (mem_re) begin
      rdata_r <= key_mem[idx_r];
    end
  end

  // Strict compare over an ascending scan keeps the lowest lane on a tie.
  assign take_best = cmp_vld_r && live_r[cmp_idx_r] &&
                     (!best_vld_r || (rdata_r < best_key_r));

  always_comb begin
    state_nxt     = state_r;
    live_nxt      = live_r;
    present_nxt   = present_r;
    done_nxt      = done_r;
    idx_nxt       = idx_r;
    cmp_vld_nxt   = 1'b0;
    cmp_idx_nxt   = cmp_idx_r;
    best_vld_nxt  = best_vld_r;
    best_idx_nxt  = best_idx_r;
    best_key_nxt  = best_key_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_lane_nxt  = out_lane_r;
    out_sec_nxt   = out_sec_r;
    out_usec_nxt  = out_usec_r;
    out_fin_nxt   = out_fin_r;
    pop_ready     = 1'b0;
    mem_we        = 1'b0;
    mem_re        = 1'b0;

    if (take_best) begin
      best_vld_nxt = 1'b1;
      best_idx_nxt = cmp_idx_r;
      best_key_nxt = rdata_r;
    end

    unique case (state_r)
      tkm_pkg::BK_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid && !done_r) begin
          state_nxt = tkm_pkg::BK_CHECK;
          if (pop_item.kind == tkm_pkg::KIND_END) begin
            live_nxt[item_idx]    = 1'b0;
            present_nxt[item_idx] = 1'b0;
          end else if (live_r[item_idx]) begin
            mem_we                = 1'b1;
            present_nxt[item_idx] = 1'b1;
          end
        end
      end
      tkm_pkg::BK_CHECK: begin
        priority if (act_live == '0) begin
          state_nxt = tkm_pkg::BK_FIN;
        end else if (&(~act_live | present_r)) begin
          state_nxt    = tkm_pkg::BK_SCAN;
          idx_nxt      = '0;
          best_vld_nxt = 1'b0;
        end else begin
          state_nxt = tkm_pkg::BK_IDLE;
        end
      end
      tkm_pkg::BK_SCAN: begin
        mem_re      = 1'b1;
        cmp_vld_nxt = 1'b1;
        cmp_idx_nxt = idx_r;
        if (CNTW'(idx_r) + CNTW'(1) == lane_count) begin
          state_nxt = tkm_pkg::BK_DRAIN;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      tkm_pkg::BK_DRAIN: begin
        state_nxt = tkm_pkg::BK_EMIT;
      end
      tkm_pkg::BK_EMIT: begin
        if (out_free) begin
          state_nxt               = tkm_pkg::BK_IDLE;
          present_nxt[best_idx_r] = 1'b0;
          out_valid_nxt           = 1'b1;
          out_lane_nxt            = tkm_pkg::LANE_W'(best_idx_r);
          out_sec_nxt             = best_key_r[KW-1:tkm_pkg::USEC_W];
          out_usec_nxt            = best_key_r[tkm_pkg::USEC_W-1:0];
          out_fin_nxt             = 1'b0;
        end
      end
      tkm_pkg::BK_FIN: begin
        if (out_free) begin
          state_nxt     = tkm_pkg::BK_IDLE;
          done_nxt      = 1'b1;
          out_valid_nxt = 1'b1;
          out_lane_nxt  = '0;
          out_sec_nxt   = '0;
          out_usec_nxt  = '0;
          out_fin_nxt   = 1'b1;
        end
      end
      default: begin
        state_nxt = tkm_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tkm_pkg::BK_IDLE;
      live_r      <= '1;
      present_r   <= '0;
      done_r      <= 1'b0;
      cmp_vld_r   <= 1'b0;
      best_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      live_r      <= live_nxt;
      present_r   <= present_nxt;
      done_r      <= done_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      best_vld_r  <= best_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    best_idx_r <= best_idx_nxt;
    best_key_r <= best_key_nxt;
    out_lane_r <= out_lane_nxt;
    out_sec_r  <= out_sec_nxt;
    out_usec_r <= out_usec_nxt;
    out_fin_r  <= out_fin_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.chosen_lane = out_lane_r;
  assign out_ch.chosen_sec  = out_sec_r;
  assign out_ch.chosen_usec = out_usec_r;
  assign out_ch.finished    = out_fin_r;

endmodule

// ===== design/timestamp_kway_merge.sv =====
// A request that emits nothing passes at most the back end's idle and check states.
// A request that completes a set of heads also runs the scan over the n lanes in use,
// which reads one stored head per cycle, then drain and emit; emit waits on a stalled
// output, and the back end pops no new request until it is back in idle.
// Reset (rst_n, synchronous, active low): all lanes live, no heads held,
// lane count 16 (or LANES if smaller); head store contents are left as they are.
module timestamp_kway_merge #(
  parameter int unsigned LANES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  tkm_in_if.sink      in_ch,
  tkm_out_if.source   out_ch,
  tkm_cfg_if.sink     cfg_ch
);

  localparam int unsigned CNTW = $clog2(LANES + 1);

  logic                push_valid;
  logic                push_ready;
  tkm_pkg::tkm_item_t  push_item;
  logic                pop_valid;
  logic                pop_ready;
  tkm_pkg::tkm_item_t  pop_item;
  logic [CNTW-1:0]     lane_count;

  tkm_front #(
    .LANES (LANES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg_ch     (cfg_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .lane_count (lane_count)
  );

  tkm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  tkm_back #(
    .LANES (LANES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .lane_count (lane_count),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item),
    .out_ch     (out_ch)
  );

endmodule

// ===== design/tkm_checker.sv =====
`include "timestamp_kway_merge_macros.svh"

module tkm_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [tkm_pkg::LANE_W-1:0]   chosen_lane,
  input logic [tkm_pkg::SEC_W-1:0]    chosen_sec,
  input logic [tkm_pkg::USEC_W-1:0]   chosen_usec,
  input logic                         finished
);

  logic fin_seen_r;
  logic fin_seen_nxt;

  assign fin_seen_nxt = fin_seen_r || (out_valid && out_ready && finished);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_seen_r <= 1'b0;
    end else begin
      fin_seen_r <= fin_seen_nxt;
    end
  end

  `TKM_ASSERT_NEXT(a_out_valid_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result request dropped while stalled")
  `TKM_ASSERT_NEXT(a_out_data_hold, clk, rst_n, out_valid && !out_ready, $stable({chosen_lane, chosen_sec, chosen_usec, finished}), "result payload changed while stalled")
  `TKM_ASSERT_NOW(a_fin_zero, clk, rst_n, out_valid && finished, (chosen_lane == '0) && (chosen_sec == '0) && (chosen_usec == '0), "finished result carries a timestamp")
  `TKM_ASSERT_NOW(a_quiet_after_fin, clk, rst_n, fin_seen_r, !out_valid, "result emitted after the merge finished")

endmodule

bind timestamp_kway_merge tkm_checker u_tkm_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .chosen_lane (out_ch.chosen_lane),
  .chosen_sec  (out_ch.chosen_sec),
  .chosen_usec (out_ch.chosen_usec),
  .finished    (out_ch.finished)
);

// ===== bench/tb.sv =====
module tb;
  import tkm_pkg::*;

  localparam int NUM_LANES      = 16;
  localparam int SETTLE_CYCLES  = 40;
  localparam int HOLD_CYCLES    = 400;
  localparam int PHASE_REQUESTS = 60;
  localparam int PRESSURE_PHASE = 9;

  localparam logic [SEC_W-1:0]  SEC_MAX   = 32'hFFFF_FFFF;
  localparam logic [USEC_W-1:0] USEC_MAX  = 20'hF_FFFF;
  localparam logic [USEC_W-1:0] USEC_TOP  = 20'd999_999;
  localparam logic [USEC_W-1:0] USEC_OVER = 20'd1_000_000;

  typedef struct packed {
    logic [LANE_W-1:0] lane;
    logic [SEC_W-1:0]  sec;
    logic [USEC_W-1:0] usec;
    logic              fin;
  } merge_res_t;

  // One directed step: either a lane-count write or a request. Where typed is set,
  // the row carries the result (or the absence of one) that the request must give.
  typedef struct packed {
    logic              wr_cfg;
    logic [CFG_W-1:0]  cfg_val;
    tkm_kind_t         kind;
    logic [LANE_W-1:0] lane;
    logic [SEC_W-1:0]  sec;
    logic [USEC_W-1:0] usec;
    logic              typed;
    logic              emits;
    logic [LANE_W-1:0] r_lane;
    logic [SEC_W-1:0]  r_sec;
    logic [USEC_W-1:0] r_usec;
    logic              r_fin;
  } plan_row_t;

  localparam plan_row_t PLAN [21] = '{
    '{1'b0, 5'd0,  KIND_HEAD, 4'd15, SEC_MAX, USEC_MAX,  1'b1, 1'b0, 4'd0, 32'd0, 20'd0, 1'b0},
    '{1'b1, 5'd1,  KIND_HEAD, 4'd0,  32'd0,   20'd0,     1'b0, 1'b0, 4'd0, 32'd0, 20'd0, 1'b0},
    '{1'b0, 5'd0,  KIND_HEAD, 4'd0,  32'd0,   20'd0,     1'b1, 1'b1, 4'd0, 32'd0, 20'd0, 1'b0},
    '{1'b0, 5'd0,  KIND_HEAD, 4'd0,  SEC_MAX, USEC_MAX,
      1'b1, 1'b1, 4'd0, SEC_MAX, USEC_MAX, 1'b0},
    '{1'b0, 5'd0,  KIND_END,  4'd9,  32'd0,   20'd0,     1'b1, 1'b0, 4'd0, 32'd0, 20'd0, 1'b0},
    '{1'b1, 5'd0,  KIND_HEAD, 4'd0,  32'd0,   20'd0,     1'b0, 1'b0, 4'd0, 32'd0, 20'd0, 1'b0},
    '{1'b0, 5'd0,  KIND_HEAD, 4'd1,  32'd1,   20'd1,     1'b1, 1'b0, 4'd0, 32'd0, 20'd0, 1'b0},
    '{1'b0, 5'd0,  KIND_HEAD, 4'd0,  32'd5,   USEC_TOP,
      1'b1, 1'b1, 4'd0, 32'd5, USEC_TOP, 1'b0},
    '{1'b1, 5'd2,  KIND_HEAD, 4'd0,  32'd0,   20'd0,     1'b0, 1'b0, 4'd0, 32'd0, 20'd0, 1'b0},
    '{1'b0, 5'd0,  KIND_HEAD, 4'd1,  32'd10,  USEC_TOP,  1'b1, 1'b0, 4'd0, 32'd0, 20'd0, 1'b0},
    '{1'b0, 5'd0,  KIND_HEAD, 4'd0,  32'd10,  USEC_TOP,
      1'b1, 1'b1, 4'd0, 32'd10, USEC_TOP, 1'b0},
    '{1'b0, 5'd0,  KIND_HEAD, 4'd0,  32'd9,   USEC_OVER,
      1'b1, 1'b1, 4'd0, 32'd9, USEC_OVER, 1'b0},
    '{1'b0, 5'd0,  KIND_HEAD, 4'd0,  32'd10,  USEC_OVER, 1'b0, 1'b0, 4'd0, 32'd0, 20'd0, 1'b0},
    '{1'b0, 5'd0,  KIND_HEAD, 4'd1,  32'd20,  20'd0,     1'b0, 1'b0, 4'd0, 32'd0, 20'd0, 1'b0},
    '{1'b0, 5'd0,  KIND_HEAD, 4'd1,  32'd3,   20'd0,     1'b0, 1'b0, 4'd0, 32'd0, 20'd0, 1'b0},
    '{1'b0, 5'd0,  KIND_HEAD, 4'd0,  32'd3,   20'd0,     1'b0, 1'b0, 4'd0, 32'd0, 20'd0, 1'b0},
    '{1'b1, 5'd31, KIND_HEAD, 4'd0,  32'd0,   20'd0,     1'b0, 1'b0, 4'd0, 32'd0, 20'd0, 1'b0},
    '{1'b0, 5'd0,  KIND_END,  4'd15, 32'd0,   20'd0,     1'b0, 1'b0, 4'd0, 32'd0, 20'd0, 1'b0},
    '{1'b0, 5'd0,  KIND_HEAD, 4'd15, 32'd7,   20'd7,     1'b0, 1'b0, 4'd0, 32'd0, 20'd0, 1'b0},
    '{1'b0, 5'd0,  KIND_END,  4'd15, 32'd0,   20'd0,     1'b0, 1'b0, 4'd0, 32'd0, 20'd0, 1'b0},
    '{1'b1, 5'd17, KIND_HEAD, 4'd0,  32'd0,   20'd0,     1'b0, 1'b0, 4'd0, 32'd0, 20'd0, 1'b0}
  };

  localparam logic [CFG_W-1:0] PHASE_CFG [13] = '{
    5'd16, 5'd3, 5'd8, 5'd1, 5'd12, 5'd0, 5'd5, 5'd31, 5'd2, 5'd16, 5'd17, 5'd7, 5'd16
  };

  logic clk = 1'b0;
  logic rst_n;
  logic hold_rx = 1'b0;
  bit   pressure_on = 1'b0;
  bit   tx_calm = 1'b0;

  // Predictor state.
  logic [CFG_W-1:0]  lane_cfg;
  logic [SEC_W-1:0]  held_sec [NUM_LANES];
  logic [USEC_W-1:0] held_usec [NUM_LANES];
  bit                held [NUM_LANES];
  bit                live [NUM_LANES];
  bit                merge_done;

  merge_res_t merged_q [$];
  merge_res_t want;
  int rx_wait = 0;
  int n_requests = 0;
  int n_results = 0;
  int n_settings = 0;
  int n_fails = 0;

  tkm_in_if  in_bus ();
  tkm_out_if out_bus ();
  tkm_cfg_if cfg_bus ();

  timestamp_kway_merge #(.LANES(NUM_LANES)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  always #5 clk = ~clk;

  function automatic int lanes_considered();
    if (lane_cfg == 0) return 1;
    if (lane_cfg > NUM_LANES) return NUM_LANES;
    return int'(lane_cfg);
  endfunction

  function automatic bit merge_step(input tkm_item_t it, output merge_res_t res);
    int n;
    int i;
    int best;
    bit any_live;
    bit all_ready;
    bit have_best;
    n = lanes_considered();
    res = '0;
    best = 0;
    any_live = 1'b0;
    all_ready = 1'b1;
    have_best = 1'b0;
    if (merge_done || int'(it.lane) >= n) return 1'b0;
    if (it.kind == KIND_END) begin
      live[it.lane] = 1'b0;
      held[it.lane] = 1'b0;
    end else if (live[it.lane]) begin
      held_sec[it.lane] = it.sec;
      held_usec[it.lane] = it.usec;
      held[it.lane] = 1'b1;
    end
    for (i = 0; i < n; i++) begin
      if (live[i]) begin
        any_live = 1'b1;
        if (!held[i]) begin
          all_ready = 1'b0;
        end else if (!have_best ||
                     {held_sec[i], held_usec[i]} < {held_sec[best], held_usec[best]}) begin
          best = i;
          have_best = 1'b1;
        end
      end
    end
    if (!any_live) begin
      merge_done = 1'b1;
      res.fin = 1'b1;
      return 1'b1;
    end
    if (!all_ready || !have_best) return 1'b0;
    held[best] = 1'b0;
    res.lane = best[LANE_W-1:0];
    res.sec = held_sec[best];
    res.usec = held_usec[best];
    return 1'b1;
  endfunction

  // Random live lane among those considered, optionally only one still waiting for a head.
  function automatic int open_lane(input bit need_empty);
    int cand [$];
    int i;
    for (i = 0; i < lanes_considered(); i++) begin
      if (live[i] && !(need_empty && held[i])) cand.push_back(i);
    end
    if (cand.size() == 0) return -1;
    return cand[$urandom_range(0, cand.size() - 1)];
  endfunction

  // Mostly refills a lane that the merge is waiting on, so that emissions keep
  // flowing; the rest replaces pending heads, hits other lanes or ends a lane.
  function automatic tkm_item_t next_request(input int end_pct, input bit end_live);
    tkm_item_t it;
    int r;
    int pick;
    bit narrow;
    r = $urandom_range(0, 99);
    narrow = ($urandom_range(0, 99) < 35);
    it.kind = KIND_HEAD;
    it.sec = narrow ? 32'($urandom_range(0, 2)) : 32'($urandom());
    it.usec = narrow ? 20'($urandom_range(0, 1)) : 20'($urandom_range(0, 20'hF_FFFF));
    if ($urandom_range(0, 19) == 0) it.sec = SEC_MAX;
    pick = open_lane(1'b1);
    if (r < end_pct) begin
      it.kind = KIND_END;
      pick = end_live ? open_lane(1'b0) : -1;
      it.lane = (pick >= 0) ? LANE_W'(pick) : LANE_W'($urandom_range(10, 15));
    end else if (r < 82 && pick >= 0) begin
      it.lane = LANE_W'(pick);
    end else if (r < 95) begin
      it.lane = LANE_W'($urandom_range(0, lanes_considered() - 1));
    end else begin
      it.lane = LANE_W'($urandom_range(0, 15));
    end
    return it;
  endfunction

  task automatic offer_request(input tkm_item_t it, input bit typed, input bit typed_emits,
                               input merge_res_t typed_res);
    int gap;
    bit emits;
    merge_res_t res;
    gap = tx_calm ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.lane <= it.lane;
    in_bus.lane_end <= (it.kind == KIND_END);
    in_bus.head_sec <= it.sec;
    in_bus.head_usec <= it.usec;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    n_requests++;
    emits = merge_step(it, res);
    if (typed) begin
      emits = typed_emits;
      res = typed_res;
    end
    if (emits) merged_q.push_back(res);
  endtask

  task automatic write_lane_count(input logic [CFG_W-1:0] v);
    cfg_bus.valid <= 1'b1;
    cfg_bus.data <= v;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    cfg_bus.valid <= 1'b0;
    lane_cfg = v;
    n_settings++;
  endtask

  // Stop offering, let every pending result arrive, then allow for requests
  // that are still being processed without producing anything.
  task automatic settle();
    in_bus.valid <= 1'b0;
    while (merged_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_bus.valid && out_bus.ready) begin
        if (merged_q.size() == 0) begin
          $error("result with nothing pending: lane %0d sec %0d usec %0d finished %0b",
                 out_bus.chosen_lane, out_bus.chosen_sec, out_bus.chosen_usec,
                 out_bus.finished);
          n_fails++;
        end else begin
          want = merged_q.pop_front();
          if (out_bus.chosen_lane !== want.lane) begin
            $error("chosen_lane: expected %0d, got %0d", want.lane, out_bus.chosen_lane);
            n_fails++;
          end
          if (out_bus.chosen_sec !== want.sec) begin
            $error("chosen_sec: expected %0d, got %0d", want.sec, out_bus.chosen_sec);
            n_fails++;
          end
          if (out_bus.chosen_usec !== want.usec) begin
            $error("chosen_usec: expected %0d, got %0d", want.usec, out_bus.chosen_usec);
            n_fails++;
          end
          if (out_bus.finished !== want.fin) begin
            $error("finished: expected %0b, got %0b", want.fin, out_bus.finished);
            n_fails++;
          end
        end
        n_results++;
        rx_wait = ((n_results / 50) % 3 == 1) ? 0 : $urandom_range(0, 8);
      end else if (rx_wait != 0) begin
        rx_wait--;
      end
      out_bus.ready <= !hold_rx && rx_wait == 0;
    end
  end

  // Long receiver stall so the block backs up and refuses requests.
  initial begin
    wait (pressure_on);
    @(posedge clk);
    hold_rx <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rx <= 1'b0;
  end

  initial begin
    #3_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    tkm_item_t it;
    merge_res_t typed_res;
    int k;
    int p;
    rst_n <= 1'b0;
    in_bus.valid <= 1'b0;
    in_bus.lane <= '0;
    in_bus.lane_end <= 1'b0;
    in_bus.head_sec <= '0;
    in_bus.head_usec <= '0;
    cfg_bus.valid <= 1'b0;
    cfg_bus.data <= '0;
    lane_cfg = CFG_W'(RST_LANES);
    merge_done = 1'b0;
    for (k = 0; k < NUM_LANES; k++) begin
      held_sec[k] = '0;
      held_usec[k] = '0;
      held[k] = 1'b0;
      live[k] = 1'b1;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (PLAN[k]) begin
      if (PLAN[k].wr_cfg) begin
        settle();
        write_lane_count(PLAN[k].cfg_val);
      end else begin
        it = '{PLAN[k].kind, PLAN[k].lane, PLAN[k].sec, PLAN[k].usec};
        typed_res = '{PLAN[k].r_lane, PLAN[k].r_sec, PLAN[k].r_usec, PLAN[k].r_fin};
        offer_request(it, PLAN[k].typed, PLAN[k].emits, typed_res);
      end
    end

    // Lanes 10 and up may end here; the low lanes stay live until the last phase.
    for (p = 0; p < $size(PHASE_CFG); p++) begin
      settle();
      write_lane_count(PHASE_CFG[p]);
      tx_calm = (p % 3 == 2);
      if (p == PRESSURE_PHASE) pressure_on = 1'b1;
      repeat (PHASE_REQUESTS) offer_request(next_request(2, 1'b0), 1'b0, 1'b0, '0);
    end

    // Wind the merge down, then show that nothing more comes out.
    settle();
    write_lane_count(5'd16);
    tx_calm = 1'b0;
    for (k = 0; k < 600 && !merge_done; k++) begin
      offer_request(next_request(25, 1'b1), 1'b0, 1'b0, '0);
    end
    repeat (6) offer_request(next_request(30, 1'b1), 1'b0, 1'b0, '0);
    settle();
    write_lane_count(5'd4);
    repeat (4) offer_request(next_request(10, 1'b0), 1'b0, 1'b0, '0);
    settle();

    $display("tb: %0d requests under %0d lane-count writes, %0d merged results checked",
             n_requests, n_settings, n_results);
    $display("tb: end of merge %s, long output stall %s",
             merge_done ? "reached" : "not reached", pressure_on ? "applied" : "skipped");
    if (n_fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/tkm_pkg.sv
design/tkm_if.sv
design/tkm_front.sv
design/tkm_queue.sv
design/tkm_back.sv
design/timestamp_kway_merge.sv
design/tkm_checker.sv
bench/tb.sv
